// ===== rtl/fmg_pkg.sv =====
`default_nettype none
package fmg_pkg;
   localparam int IDX_W  = 10;
   localparam int DIM_W  = 11;
   localparam int OFF_W  = 11;
   localparam int RAD_W  = 10;
   localparam int ORD_W  = 2;
   localparam int KIND_W = 2;
   localparam int D2_W   = 21;
   localparam int DD2_W  = 20;
   localparam int LIM_W  = 21;
   localparam int POW_W  = 64;
   localparam int OUT_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam int DEF_MAX_DIM   = 1024;
   localparam int DEF_MAX_ORDER = 3;
   localparam int DEF_FRAC_BITS = 15;

   localparam logic [KIND_W-1:0] KIND_BW_LOW   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BW_HIGH  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ID_LOW   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ID_HIGH  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_KIND   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 3'd4;

   typedef struct packed {
      logic forced;
      logic full;
   } side_type;
endpackage
`default_nettype wire

// ===== rtl/fmg_dist_pipe.sv =====
`default_nettype none
module fmg_dist_pipe #(
   parameter int MAX_DIM = fmg_pkg::DEF_MAX_DIM
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [fmg_pkg::IDX_W-1:0]   row_index,
   input  wire logic [fmg_pkg::IDX_W-1:0]   col_index,
   input  wire logic [fmg_pkg::DIM_W-1:0]   row_count,
   input  wire logic [fmg_pkg::DIM_W-1:0]   col_count,
   input  wire logic [fmg_pkg::RAD_W-1:0]   cutoff_radius,
   output logic                             out_valid,
   output logic [fmg_pkg::D2_W-1:0]         d2,
   output logic [fmg_pkg::DD2_W-1:0]        dd2
);
   import fmg_pkg::*;

   localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM);

   logic [DIM_W-1:0] rows_sat, cols_sat;
   logic signed [OFF_W-1:0] dr_in, dc_in, dr_ff, dc_ff;
   logic signed [2*OFF_W-1:0] sqr_full, sqc_full;
   logic [D2_W-1:0] sqr_in, sqc_in, sqr_ff, sqc_ff, d2_in, d2_ff;
   logic [DD2_W-1:0] dd2a_in, dd2a_ff, dd2b_ff;
   logic v1_ff, v2_ff, v3_ff;

   always_comb begin
      rows_sat = (row_count > DIM_CAP) ? DIM_CAP : row_count;
      cols_sat = (col_count > DIM_CAP) ? DIM_CAP : col_count;
      dr_in = $signed({1'b0, row_index} - {1'b0, rows_sat[DIM_W-1:1]});
      dc_in = $signed({1'b0, col_index} - {1'b0, cols_sat[DIM_W-1:1]});
      sqr_full = dr_ff * dr_ff;
      sqc_full = dc_ff * dc_ff;
      sqr_in = sqr_full[D2_W-1:0];
      sqc_in = sqc_full[D2_W-1:0];
      dd2a_in = cutoff_radius * cutoff_radius;
      d2_in = sqr_ff + sqc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dr_ff   <= dr_in;
         dc_ff   <= dc_in;
         sqr_ff  <= sqr_in;
         sqc_ff  <= sqc_in;
         dd2a_ff <= dd2a_in;
         d2_ff   <= d2_in;
         dd2b_ff <= dd2a_ff;
      end
   end

   assign out_valid = v3_ff;
   assign d2        = d2_ff;
   assign dd2       = dd2b_ff;
endmodule
`default_nettype wire

// ===== rtl/fmg_power_pipe.sv =====
`default_nettype none
module fmg_power_pipe #(
   parameter int MAX_ORDER = fmg_pkg::DEF_MAX_ORDER
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [fmg_pkg::D2_W-1:0]    d2,
   input  wire logic [fmg_pkg::DD2_W-1:0]   dd2,
   input  wire logic [fmg_pkg::KIND_W-1:0]  filter_kind,
   input  wire logic [fmg_pkg::RAD_W-1:0]   cutoff_radius,
   input  wire logic [fmg_pkg::ORD_W-1:0]   filter_order,
   output logic                             out_valid,
   output logic [fmg_pkg::POW_W-1:0]        num,
   output logic [fmg_pkg::POW_W-1:0]        den,
   output fmg_pkg::side_type                side
);
   import fmg_pkg::*;

   localparam logic [ORD_W-1:0] ORD_CAP = ORD_W'(MAX_ORDER);
   localparam int P2_W = 2 * D2_W;
   localparam int Q2_W = 2 * DD2_W;

   logic v4_ff, v5_ff, v6_ff, v7_ff;
   logic [D2_W-1:0]  d2a_ff, d2b_ff;
   logic [DD2_W-1:0] dda_ff, ddb_ff;
   logic [P2_W-1:0]  p2_in, p2a_ff, p2b_ff, p3lo_in, p3hi_in, p3lo_ff, p3hi_ff;
   logic [Q2_W-1:0]  q2_in, q2a_ff, q2b_ff, q3lo_in, q3hi_in, q3lo_ff, q3hi_ff;
   logic [LIM_W-1:0] lim_in, lim_ff;
   logic [RAD_W:0]   rad1;
   logic inside_in, inside_a_ff, inside_b_ff;
   logic [ORD_W-1:0] nsat;
   logic [POW_W-1:0] p3, q3, pr_in, pd_in, pr_ff, pd_ff;
   logic [POW_W-1:0] num_in, den_in, num_ff, den_ff;
   side_type side_in, side_ff;

   always_comb begin
      rad1 = {1'b0, cutoff_radius} + 1'b1;
      lim_in = rad1 * rad1;
      p2_in = d2 * d2;
      q2_in = dd2 * dd2;
      p3lo_in = p2a_ff[D2_W-1:0] * d2a_ff;
      p3hi_in = p2a_ff[P2_W-1:D2_W] * d2a_ff;
      q3lo_in = q2a_ff[DD2_W-1:0] * dda_ff;
      q3hi_in = q2a_ff[Q2_W-1:DD2_W] * dda_ff;
      inside_in = {1'b0, d2a_ff} < {1'b0, lim_ff};
      p3 = POW_W'(p3lo_ff) + (POW_W'(p3hi_ff) << D2_W);
      q3 = POW_W'(q3lo_ff) + (POW_W'(q3hi_ff) << DD2_W);
      nsat = (filter_order > ORD_CAP) ? ORD_CAP : filter_order;
      case (nsat)
         2'd0: begin
            pr_in = POW_W'(1);
            pd_in = POW_W'(1);
         end
         2'd1: begin
            pr_in = POW_W'(d2b_ff);
            pd_in = POW_W'(ddb_ff);
         end
         2'd2: begin
            pr_in = POW_W'(p2b_ff);
            pd_in = POW_W'(q2b_ff);
         end
         default: begin
            pr_in = p3;
            pd_in = q3;
         end
      endcase
      den_in = pd_ff + pr_ff;
      num_in = (filter_kind == KIND_BW_LOW) ? pd_ff : pr_ff;
      side_in.forced = 1'b0;
      side_in.full   = 1'b0;
      if (filter_kind == KIND_ID_LOW) begin
         side_in.forced = 1'b1;
         side_in.full   = inside_b_ff;
      end else if (filter_kind == KIND_ID_HIGH) begin
         side_in.forced = 1'b1;
         side_in.full   = !inside_b_ff;
      end else if (den_in == '0) begin
         side_in.forced = 1'b1;
         side_in.full   = (filter_kind == KIND_BW_LOW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2a_ff <= d2;
         dda_ff <= dd2;
         p2a_ff <= p2_in;
         q2a_ff <= q2_in;
         lim_ff <= lim_in;
         d2b_ff <= d2a_ff;
         ddb_ff <= dda_ff;
         p2b_ff <= p2a_ff;
         q2b_ff <= q2a_ff;
         p3lo_ff <= p3lo_in;
         p3hi_ff <= p3hi_in;
         q3lo_ff <= q3lo_in;
         q3hi_ff <= q3hi_in;
         inside_a_ff <= inside_in;
         pr_ff <= pr_in;
         pd_ff <= pd_in;
         inside_b_ff <= inside_a_ff;
         num_ff  <= num_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v7_ff;
   assign num  = num_ff;
   assign den  = den_ff;
   assign side = side_ff;
endmodule
`default_nettype wire

// ===== rtl/fmg_div_pipe.sv =====
`default_nettype none
module fmg_div_pipe #(
   parameter int FRAC_BITS = fmg_pkg::DEF_FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [fmg_pkg::POW_W-1:0]  num,
   input  wire logic [fmg_pkg::POW_W-1:0]  den,
   input  fmg_pkg::side_type               side,
   output logic                            out_valid,
   output logic [FRAC_BITS+1:0]            quo,
   output fmg_pkg::side_type               out_side
);
   import fmg_pkg::*;

   localparam int NS = FRAC_BITS + 1;
   localparam int QW = FRAC_BITS + 2;

   logic             v_ff   [0:NS];
   logic [POW_W-1:0] rem_ff [0:NS];
   logic [POW_W-1:0] den_ff [0:NS];
   logic [QW-1:0]    quo_ff [0:NS];
   side_type         side_ff[0:NS];

   logic first_ge;
   assign first_ge = num >= den;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= first_ge ? num - den : num;
         quo_ff[0]  <= QW'(first_ge);
         den_ff[0]  <= den;
         side_ff[0] <= side;
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic [POW_W:0] rem2, den_x;
      logic ge;
      always_comb begin
         rem2  = {rem_ff[k-1], 1'b0};
         den_x = {1'b0, den_ff[k-1]};
         ge    = rem2 >= den_x;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? POW_W'(rem2 - den_x) : rem2[POW_W-1:0];
            quo_ff[k]  <= {quo_ff[k-1][QW-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign quo       = quo_ff[NS];
   assign out_side  = side_ff[NS];
endmodule
`default_nettype wire

// ===== rtl/frequency_filter_mask_generator_core.sv =====
`default_nettype none
// Radial frequency-plane filter mask: each item is a (row, column) coordinate and yields one
// gain in unsigned fixed point with FRAC_BITS fraction bits (Butterworth or ideal, lowpass or
// highpass, selected by csr register 0). One item is accepted every clock while the result side
// takes items. The pipeline holds three distance stages, four power stages (squares and a split
// cube), one restoring-divider stage per quotient bit (FRAC_BITS + 2 of them), and the rounding
// output register. Csr writes must happen only while the block is empty.
module frequency_filter_mask_generator_core #(
   parameter int MAX_DIM   = fmg_pkg::DEF_MAX_DIM,
   parameter int MAX_ORDER = fmg_pkg::DEF_MAX_ORDER,
   parameter int FRAC_BITS = fmg_pkg::DEF_FRAC_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [fmg_pkg::IDX_W-1:0]       req_row_index,
   input  wire logic [fmg_pkg::IDX_W-1:0]       req_col_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [fmg_pkg::OUT_W-1:0]            rsp_mask_value,
   input  wire logic                            csr_write_enable,
   input  wire logic [fmg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fmg_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import fmg_pkg::*;

   localparam int QW = FRAC_BITS + 2;
   localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
   localparam logic [QW-1:0] OUT_MAX = QW'(17'h0FFFF);

   logic [KIND_W-1:0] kind_ff;
   logic [RAD_W-1:0]  radius_ff;
   logic [ORD_W-1:0]  order_ff;
   logic [DIM_W-1:0]  rows_ff, cols_ff;

   logic en;
   logic dist_valid, pow_valid, div_valid;
   logic [D2_W-1:0]  d2;
   logic [DD2_W-1:0] dd2;
   logic [POW_W-1:0] num, den;
   side_type pow_side, div_side;
   logic [QW-1:0] quo, gain;
   logic [QW:0] rnd;
   logic rsp_valid_ff;
   logic [OUT_W-1:0] mask_in, mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_BW_HIGH;
         radius_ff <= RAD_W'(80);
         order_ff  <= ORD_W'(2);
         rows_ff   <= DIM_W'(512);
         cols_ff   <= DIM_W'(512);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KIND:   kind_ff   <= csr_write_data[KIND_W-1:0];
            CSR_RADIUS: radius_ff <= csr_write_data[RAD_W-1:0];
            CSR_ORDER:  order_ff  <= csr_write_data[ORD_W-1:0];
            CSR_ROWS:   rows_ff   <= csr_write_data[DIM_W-1:0];
            CSR_COLS:   cols_ff   <= csr_write_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   fmg_dist_pipe #(.MAX_DIM(MAX_DIM)) u_dist (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid & en),
      .row_index(req_row_index), .col_index(req_col_index),
      .row_count(rows_ff), .col_count(cols_ff), .cutoff_radius(radius_ff),
      .out_valid(dist_valid), .d2(d2), .dd2(dd2)
   );

   fmg_power_pipe #(.MAX_ORDER(MAX_ORDER)) u_power (
      .clock(clock), .reset(reset), .en(en), .in_valid(dist_valid),
      .d2(d2), .dd2(dd2), .filter_kind(kind_ff), .cutoff_radius(radius_ff),
      .filter_order(order_ff), .out_valid(pow_valid), .num(num), .den(den),
      .side(pow_side)
   );

   fmg_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(pow_valid),
      .num(num), .den(den), .side(pow_side),
      .out_valid(div_valid), .quo(quo), .out_side(div_side)
   );

   always_comb begin
      rnd = ({1'b0, quo} + 1'b1) >> 1;
      if (div_side.forced) begin
         gain = div_side.full ? ONE_Q : '0;
      end else begin
         gain = rnd[QW-1:0];
      end
      mask_in = (gain > OUT_MAX) ? OUT_W'(16'hFFFF) : OUT_W'(gain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mask_ff <= mask_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mask_value = mask_ff;

   localparam logic [OUT_W-1:0] SAT_ONE =
      (ONE_Q > OUT_MAX) ? OUT_W'(16'hFFFF) : OUT_W'(ONE_Q);

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mask_value <= SAT_ONE)
      else $error("mask value above unity");

   a_ideal_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind_ff[1] |-> rsp_mask_value == '0 || rsp_mask_value == SAT_ONE)
      else $error("ideal filter gain not binary");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while output stalled");
endmodule
`default_nettype wire
